// File: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked at every rising edge of clock outside reset
`define SEMO_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition that must never be seen
`define SEMO_ASSERT_NEVER(lbl, expr, msg) \
   `SEMO_ASSERT(lbl, !(expr), msg)

`else

`define SEMO_ASSERT(lbl, prop, msg)
`define SEMO_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: sv/semo_pkg.sv
package semo_pkg;

   localparam int unsigned DEF_MAX_WIDTH = 2048;
   localparam int unsigned MAX_HEIGHT    = 4096;
   localparam int unsigned MIN_DIM       = 3;

   localparam int unsigned PIXEL_W   = 8;
   localparam int unsigned OUT_COL_W = 11;
   localparam int unsigned ROW_W     = 12;
   localparam int unsigned IW_W      = 12;
   localparam int unsigned IH_W      = 13;
   localparam int unsigned THR_W     = 9;
   localparam int unsigned COLOR_W   = 8;
   localparam int unsigned MAG_W     = 8;

   localparam int unsigned SUM_W     = PIXEL_W + 2;
   localparam int unsigned GRAD_W    = SUM_W + 1;
   localparam int unsigned SQ_W      = 2 * SUM_W;
   localparam int unsigned MAG_SHIFT = 4;
   localparam int unsigned RAD_W     = SQ_W + 1 - MAG_SHIFT;

   localparam int unsigned SQRT_STEPS_PER_STAGE = 2;
   localparam int unsigned SQRT_STAGES          = MAG_W / SQRT_STEPS_PER_STAGE;

   localparam logic [MAG_W-1:0] MAG_SAT = {MAG_W{1'b1}};

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = IH_W;

   localparam logic [IW_W-1:0]    RST_IMAGE_WIDTH    = IW_W'(640);
   localparam logic [IH_W-1:0]    RST_IMAGE_HEIGHT   = IH_W'(480);
   localparam logic [THR_W-1:0]   RST_EDGE_THRESHOLD = THR_W'(64);
   localparam logic [COLOR_W-1:0] RST_EDGE_RED       = COLOR_W'(255);
   localparam logic [COLOR_W-1:0] RST_EDGE_GREEN     = COLOR_W'(0);
   localparam logic [COLOR_W-1:0] RST_EDGE_BLUE      = COLOR_W'(0);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_EDGE_THRESHOLD = 3'd2,
      CSR_EDGE_RED       = 3'd3,
      CSR_EDGE_GREEN     = 3'd4,
      CSR_EDGE_BLUE      = 3'd5
   } semo_csr_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } semo_req_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0] out_col;
      logic [ROW_W-1:0]     out_row;
      logic [MAG_W-1:0]     magnitude;
      logic                 is_edge;
      logic [COLOR_W-1:0]   ovl_red;
      logic [COLOR_W-1:0]   ovl_green;
      logic [COLOR_W-1:0]   ovl_blue;
      logic [MAG_W-1:0]     ovl_alpha;
      logic                 frame_end;
   } semo_rsp_type;

   typedef struct packed {
      logic [OUT_COL_W-1:0] out_col;
      logic [ROW_W-1:0]     out_row;
      logic                 frame_end;
   } semo_side_type;

endpackage

// File: sv/semo_ram.sv
module semo_ram import semo_pkg::*; #(
   parameter int unsigned WIDTH = PIXEL_W,
   parameter int unsigned DEPTH = DEF_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/semo_window.sv
module semo_window import semo_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
   input  logic [PIXEL_W-1:0]           in_pixel,
   input  logic                         in_produced,
   input  semo_side_type                in_side,
   output logic                         out_valid,
   output logic signed [GRAD_W-1:0]     out_gx,
   output logic signed [GRAD_W-1:0]     out_gy,
   output semo_side_type                out_side
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);

   logic                s1_valid_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic [PIXEL_W-1:0]  s1_pixel_ff;
   logic                s1_produced_ff;
   semo_side_type       s1_side_ff;

   logic                fwd_ff;
   logic [PIXEL_W-1:0]  fwd_top_ff;
   logic [PIXEL_W-1:0]  fwd_mid_ff;

   logic [PIXEL_W-1:0]  rd_two_above;
   logic [PIXEL_W-1:0]  rd_above;
   logic [PIXEL_W-1:0]  top;
   logic [PIXEL_W-1:0]  mid;
   logic [PIXEL_W-1:0]  bot;
   logic                wr_en;

   logic [PIXEL_W-1:0]  win_ff [6];

   logic [SUM_W-1:0]    sum_right;
   logic [SUM_W-1:0]    sum_left;
   logic [SUM_W-1:0]    sum_bottom;
   logic [SUM_W-1:0]    sum_top;
   logic signed [GRAD_W-1:0] gx_in;
   logic signed [GRAD_W-1:0] gy_in;

   logic                s2_valid_ff;
   logic signed [GRAD_W-1:0] s2_gx_ff;
   logic signed [GRAD_W-1:0] s2_gy_ff;
   semo_side_type       s2_side_ff;

   assign wr_en = en && s1_valid_ff;
   assign bot   = s1_pixel_ff;

   semo_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_two_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (mid),
      .rd_en   (in_valid),
      .rd_addr (in_col),
      .rd_data (rd_two_above)
   );

   semo_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (bot),
      .rd_en   (in_valid),
      .rd_addr (in_col),
      .rd_data (rd_above)
   );

   // write-back of the item ahead races the read at the same column
   assign top = fwd_ff ? fwd_top_ff : rd_two_above;
   assign mid = fwd_ff ? fwd_mid_ff : rd_above;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         fwd_ff      <= in_valid && s1_valid_ff && (in_col == s1_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         s1_col_ff      <= in_col;
         s1_pixel_ff    <= in_pixel;
         s1_produced_ff <= in_produced;
         s1_side_ff     <= in_side;
         fwd_top_ff     <= mid;
         fwd_mid_ff     <= bot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (wr_en) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= bot;
      end
   end

   always_comb begin
      sum_right  = SUM_W'(top) + (SUM_W'(mid) << 1) + SUM_W'(bot);
      sum_left   = SUM_W'(win_ff[0]) + (SUM_W'(win_ff[1]) << 1) + SUM_W'(win_ff[2]);
      sum_bottom = SUM_W'(win_ff[2]) + (SUM_W'(win_ff[5]) << 1) + SUM_W'(bot);
      sum_top    = SUM_W'(win_ff[0]) + (SUM_W'(win_ff[3]) << 1) + SUM_W'(top);
      gx_in      = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      gy_in      = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff && s1_produced_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff && s1_produced_ff) begin
         s2_gx_ff   <= gx_in;
         s2_gy_ff   <= gy_in;
         s2_side_ff <= s1_side_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_gx    = s2_gx_ff;
   assign out_gy    = s2_gy_ff;
   assign out_side  = s2_side_ff;

endmodule

// File: sv/semo_isqrt.sv
module semo_isqrt import semo_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [RAD_W-1:0]   in_radicand,
   input  semo_side_type      in_side,
   output logic               out_valid,
   output logic [MAG_W-1:0]   out_mag,
   output semo_side_type      out_side
);

   typedef struct packed {
      logic [2*MAG_W-1:0] bits;
      logic [MAG_W-1:0]   root;
      logic [MAG_W:0]     rem;
      logic               sat;
   } sqrt_work_type;

   // restoring square root, one result bit per step
   function automatic sqrt_work_type sqrt_steps(sqrt_work_type cur);
      sqrt_work_type  nxt;
      logic [MAG_W+2:0] acc;
      logic [MAG_W+2:0] trial;
      nxt = cur;
      for (int i = 0; i < SQRT_STEPS_PER_STAGE; i++) begin
         acc      = {nxt.rem, nxt.bits[2*MAG_W-1 -: 2]};
         trial    = {1'b0, nxt.root, 2'b01};
         nxt.bits = nxt.bits << 2;
         if (acc >= trial) begin
            nxt.rem  = (MAG_W+1)'(acc - trial);
            nxt.root = {nxt.root[MAG_W-2:0], 1'b1};
         end else begin
            nxt.rem  = acc[MAG_W:0];
            nxt.root = {nxt.root[MAG_W-2:0], 1'b0};
         end
      end
      return nxt;
   endfunction

   sqrt_work_type st_ff   [SQRT_STAGES];
   sqrt_work_type st_in   [SQRT_STAGES];
   logic          vld_ff  [SQRT_STAGES];
   semo_side_type side_ff [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      sqrt_work_type src;
      logic          src_vld;
      semo_side_type src_side;

      if (s == 0) begin : g_first
         always_comb begin
            src.bits = in_radicand[2*MAG_W-1:0];
            src.root = '0;
            src.rem  = '0;
            src.sat  = in_radicand[RAD_W-1];
         end
         assign src_vld  = in_valid;
         assign src_side = in_side;
      end else begin : g_next
         assign src      = st_ff[s-1];
         assign src_vld  = vld_ff[s-1];
         assign src_side = side_ff[s-1];
      end

      assign st_in[s] = sqrt_steps(src);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en && src_vld) begin
            st_ff[s]   <= st_in[s];
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign out_mag   = st_ff[SQRT_STAGES-1].sat ? MAG_SAT : st_ff[SQRT_STAGES-1].root;
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

// File: sv/sobel_edge_magnitude_overlay_top.sv
// results pass window, square, sum, sqrt and output registers to rsp_valid
// throughput: one pixel per clock; each pixel does one read and one write-back
// on each of the two line-store memories, and the whole pipeline holds while
// a result waits under rsp_stall
// reset: synchronous; clears counters, window, pipeline and config to defaults;
// line stores are not cleared and need no clearing pass
`include "assert_macros.svh"

module sobel_edge_magnitude_overlay_top import semo_pkg::*; #(
   parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  semo_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output semo_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned GEO_W = (COL_W + 1 > IW_W) ? COL_W + 1 : IW_W;

   logic [IW_W-1:0]    image_width_ff;
   logic [IH_W-1:0]    image_height_ff;
   logic [THR_W-1:0]   edge_threshold_ff;
   logic [COLOR_W-1:0] edge_red_ff;
   logic [COLOR_W-1:0] edge_green_ff;
   logic [COLOR_W-1:0] edge_blue_ff;

   logic [GEO_W-1:0]   w_eff;
   logic [IH_W-1:0]    h_eff;

   logic               en;
   logic               accept;
   logic [COL_W-1:0]   col_count_ff;
   logic [COL_W-1:0]   col_count_in;
   logic [ROW_W-1:0]   row_count_ff;
   logic [ROW_W-1:0]   row_count_in;
   logic [COL_W-1:0]   col_cur;
   logic [ROW_W-1:0]   row_cur;
   logic               col_last;
   logic               row_last;
   logic               produced;
   semo_side_type      acc_side;

   logic                     win_valid;
   logic signed [GRAD_W-1:0] win_gx;
   logic signed [GRAD_W-1:0] win_gy;
   semo_side_type            win_side;

   logic signed [2*GRAD_W-1:0] gx_prod;
   logic signed [2*GRAD_W-1:0] gy_prod;
   logic                s3_valid_ff;
   logic [SQ_W-1:0]     sqx_ff;
   logic [SQ_W-1:0]     sqy_ff;
   semo_side_type       s3_side_ff;

   logic [SQ_W:0]       sq_sum;
   logic                s4_valid_ff;
   logic [RAD_W-1:0]    rad_ff;
   semo_side_type       s4_side_ff;

   logic                sqrt_valid;
   logic [MAG_W-1:0]    sqrt_mag;
   semo_side_type       sqrt_side;
   logic                is_edge;

   logic                rsp_valid_ff;
   semo_rsp_type        rsp_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff    <= RST_IMAGE_WIDTH;
         image_height_ff   <= RST_IMAGE_HEIGHT;
         edge_threshold_ff <= RST_EDGE_THRESHOLD;
         edge_red_ff       <= RST_EDGE_RED;
         edge_green_ff     <= RST_EDGE_GREEN;
         edge_blue_ff      <= RST_EDGE_BLUE;
      end else if (csr_valid && csr_ready) begin
         case (semo_csr_type'(csr_index))
            CSR_IMAGE_WIDTH:    image_width_ff    <= csr_data[IW_W-1:0];
            CSR_IMAGE_HEIGHT:   image_height_ff   <= csr_data[IH_W-1:0];
            CSR_EDGE_THRESHOLD: edge_threshold_ff <= csr_data[THR_W-1:0];
            CSR_EDGE_RED:       edge_red_ff       <= csr_data[COLOR_W-1:0];
            CSR_EDGE_GREEN:     edge_green_ff     <= csr_data[COLOR_W-1:0];
            CSR_EDGE_BLUE:      edge_blue_ff      <= csr_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp geometry into the supported range
   always_comb begin
      if (GEO_W'(image_width_ff) < GEO_W'(MIN_DIM)) begin
         w_eff = GEO_W'(MIN_DIM);
      end else if (GEO_W'(image_width_ff) > GEO_W'(MAX_WIDTH)) begin
         w_eff = GEO_W'(MAX_WIDTH);
      end else begin
         w_eff = GEO_W'(image_width_ff);
      end
      if (image_height_ff < IH_W'(MIN_DIM)) begin
         h_eff = IH_W'(MIN_DIM);
      end else if (image_height_ff > IH_W'(MAX_HEIGHT)) begin
         h_eff = IH_W'(MAX_HEIGHT);
      end else begin
         h_eff = image_height_ff;
      end
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   always_comb begin
      col_cur  = req_data.frame_start ? '0 : col_count_ff;
      row_cur  = req_data.frame_start ? '0 : row_count_ff;
      col_last = (GEO_W'(col_cur) + GEO_W'(1)) >= w_eff;
      row_last = (IH_W'(row_cur) + IH_W'(1)) >= h_eff;
      if (col_last) begin
         col_count_in = '0;
         row_count_in = row_last ? '0 : row_cur + ROW_W'(1);
      end else begin
         col_count_in = col_cur + COL_W'(1);
         row_count_in = row_cur;
      end
      produced           = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2));
      acc_side.out_col   = OUT_COL_W'(col_cur - COL_W'(1));
      acc_side.out_row   = row_cur - ROW_W'(1);
      acc_side.frame_end = col_last && row_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   semo_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (accept),
      .in_col      (col_cur),
      .in_pixel    (req_data.pixel),
      .in_produced (produced),
      .in_side     (acc_side),
      .out_valid   (win_valid),
      .out_gx      (win_gx),
      .out_gy      (win_gy),
      .out_side    (win_side)
   );

   assign gx_prod = win_gx * win_gx;
   assign gy_prod = win_gy * win_gy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= win_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      if (en && win_valid) begin
         sqx_ff     <= gx_prod[SQ_W-1:0];
         sqy_ff     <= gy_prod[SQ_W-1:0];
         s3_side_ff <= win_side;
      end
      if (en && s3_valid_ff) begin
         rad_ff     <= sq_sum[SQ_W -: RAD_W];
         s4_side_ff <= s3_side_ff;
      end
   end

   semo_isqrt u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s4_valid_ff),
      .in_radicand (rad_ff),
      .in_side     (s4_side_ff),
      .out_valid   (sqrt_valid),
      .out_mag     (sqrt_mag),
      .out_side    (sqrt_side)
   );

   assign is_edge = THR_W'(sqrt_mag) >= edge_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && sqrt_valid) begin
         rsp_data_ff.out_col   <= sqrt_side.out_col;
         rsp_data_ff.out_row   <= sqrt_side.out_row;
         rsp_data_ff.magnitude <= sqrt_mag;
         rsp_data_ff.is_edge   <= is_edge;
         rsp_data_ff.ovl_red   <= is_edge ? edge_red_ff : '0;
         rsp_data_ff.ovl_green <= is_edge ? edge_green_ff : '0;
         rsp_data_ff.ovl_blue  <= is_edge ? edge_blue_ff : '0;
         rsp_data_ff.ovl_alpha <= is_edge ? sqrt_mag : '0;
         rsp_data_ff.frame_end <= sqrt_side.frame_end;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SEMO_ASSERT(a_hold_on_stall, (rsp_valid && rsp_stall) |-> req_stall, "item taken while result held")
   `SEMO_ASSERT_NEVER(a_no_color_off_edge, rsp_valid && !rsp_data.is_edge && (rsp_data.ovl_alpha != '0 || rsp_data.ovl_red != '0 || rsp_data.ovl_green != '0 || rsp_data.ovl_blue != '0), "overlay set on non-edge item")
   `SEMO_ASSERT(a_alpha_is_mag, (rsp_valid && rsp_data.is_edge) |-> (rsp_data.ovl_alpha == rsp_data.magnitude), "edge alpha differs from magnitude")

endmodule
